FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define CHK_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// next-cycle implication, disabled while reset is asserted
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

FILE: sv/msom_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msom_pkg
// types and constants of the multi-source offline monitor
// ----------------------------------------------------------------------------
package msom_pkg;

	// source count and widths
	localparam int NSRC      = 8;
	localparam int SRC_W     = 3;
	localparam int IDX_W     = 4;
	localparam int TIME_BITS = 32;
	localparam int LIM_W     = 16;
	localparam int PRIO_W    = 4;
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 3;

	localparam logic [IDX_W-1:0] NONE_IDX = IDX_W'(8);

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OFFLINE_LO = 3'd0,
		CFG_OFFLINE_HI = 3'd1,
		CFG_ONLINE_LO  = 3'd2,
		CFG_ONLINE_HI  = 3'd3,
		CFG_PRIORITIES = 3'd4,
		CFG_ENABLE     = 3'd5
	} cfg_reg_t;

	// register reset values
	localparam logic [63:0] RST_OFFLINE_LO = 64'd1407396360355870;
	localparam logic [63:0] RST_OFFLINE_HI = 64'd140741783327211570;
	localparam logic [63:0] RST_ONLINE_LO  = 64'd2814792716976131;
	localparam logic [63:0] RST_ONLINE_HI  = 64'd140741783322886147;
	localparam logic [31:0] RST_PRIORITIES = 32'd3383540702;
	localparam logic [NSRC-1:0] RST_ENABLE = '1;

	// input operation codes
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_HOOK = 1'b1;

	typedef struct packed {
		logic             op;
		logic [SRC_W-1:0] source;
		logic             data_bad;
	} in_item_t;

	typedef struct packed {
		logic [7:0]       error_bits;
		logic [7:0]       lost_bits;
		logic             any_offline;
		logic [IDX_W-1:0] worst_source;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} msom_state_t;

endpackage

FILE: sv/multi_source_offline_monitor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_source_offline_monitor_unit
// heartbeat watchdog over eight sources with a wrapping tick counter
// ----------------------------------------------------------------------------
// A tick request is accepted while idle, then scanned one source per cycle
// through a single shared subtract-and-compare unit over the seen/rejoin time
// registers, and its result is loaded into the output register from the done
// state. A heard-source request goes from acceptance straight to that state.
// A new request is taken whenever the unit is idle, even while the
// previous result still waits in the output register; the result of the next
// request waits in its final state until that register is free.
`include "assert_macros.svh"

module multi_source_offline_monitor_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  msom_pkg::in_item_t                 in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output msom_pkg::out_item_t                out_data,
	input  logic                               cfg_we,
	input  logic [msom_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [msom_pkg::CFG_W-1:0]         cfg_data
);
	import msom_pkg::*;

	// configuration registers
	logic [63:0]     off_lo_q, off_hi_q, on_lo_q, on_hi_q;
	logic [31:0]     prio_q;
	logic [NSRC-1:0] enable_q;

	// monitor state
	logic [TIME_BITS-1:0] now_q;
	logic [TIME_BITS-1:0] seen_time_q   [NSRC];
	logic [TIME_BITS-1:0] rejoin_time_q [NSRC];
	logic [NSRC-1:0]      lost_flags_q, error_flags_q, bad_flags_q;
	logic                 offline_summary_q;
	logic [IDX_W-1:0]     worst_index_q;

	// scan working registers
	msom_state_t         state_q, state_d;
	logic [SRC_W-1:0]    idx_q;
	logic                any_q;
	logic [IDX_W-1:0]    worst_w_q;
	logic [PRIO_W-1:0]   wprio_q;

	// output register
	logic      out_valid_q;
	out_item_t out_data_q;

	// control
	logic in_acc, scan_en, scan_last, load_out;

	// shared scan unit signals
	logic [127:0]         off_all, on_all;
	logic [LIM_W-1:0]     off_lim, on_lim;
	logic [PRIO_W-1:0]    cur_prio;
	logic [TIME_BITS-1:0] since_seen, since_rejoin;
	logic                 src_en, is_off, is_stab;
	logic                 any_nxt;
	logic [IDX_W-1:0]     worst_nxt;
	logic [PRIO_W-1:0]    wprio_nxt;

	assign in_acc    = in_valid && in_ready;
	assign scan_last = (idx_q == SRC_W'(NSRC - 1));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = (in_data.op == OP_TICK) ? ST_SCAN : ST_DONE;
				end
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_ready = 1'b0;
		scan_en  = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_SCAN: scan_en  = 1'b1;
			ST_DONE: load_out = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_lo_q <= RST_OFFLINE_LO;
			off_hi_q <= RST_OFFLINE_HI;
			on_lo_q  <= RST_ONLINE_LO;
			on_hi_q  <= RST_ONLINE_HI;
			prio_q   <= RST_PRIORITIES;
			enable_q <= RST_ENABLE;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_OFFLINE_LO: off_lo_q <= cfg_data;
				CFG_OFFLINE_HI: off_hi_q <= cfg_data;
				CFG_ONLINE_LO:  on_lo_q  <= cfg_data;
				CFG_ONLINE_HI:  on_hi_q  <= cfg_data;
				CFG_PRIORITIES: prio_q   <= cfg_data[31:0];
				CFG_ENABLE:     enable_q <= cfg_data[NSRC-1:0];
				default: ;
			endcase
		end
	end

	// shared subtract-and-compare unit, one source per cycle
	always_comb begin
		off_all      = {off_hi_q, off_lo_q};
		on_all       = {on_hi_q, on_lo_q};
		off_lim      = off_all[{idx_q, 4'b0000} +: LIM_W];
		on_lim       = on_all[{idx_q, 4'b0000} +: LIM_W];
		cur_prio     = prio_q[{idx_q, 2'b00} +: PRIO_W];
		since_seen   = now_q - seen_time_q[idx_q];
		since_rejoin = now_q - rejoin_time_q[idx_q];
		src_en       = enable_q[idx_q];
		is_off       = since_seen > TIME_BITS'(off_lim);
		is_stab      = since_rejoin < TIME_BITS'(on_lim);
		any_nxt      = any_q;
		worst_nxt    = worst_w_q;
		wprio_nxt    = wprio_q;
		if (src_en && is_off) begin
			any_nxt = 1'b1;
			if (cur_prio > wprio_q) begin
				worst_nxt = {1'b0, idx_q};
				wprio_nxt = cur_prio;
			end
		end
	end

	// scan sequencing and working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q             <= '0;
			any_q             <= 1'b0;
			worst_w_q         <= NONE_IDX;
			wprio_q           <= '0;
			offline_summary_q <= 1'b0;
			worst_index_q     <= NONE_IDX;
		end else if (in_acc && in_data.op == OP_TICK) begin
			idx_q     <= '0;
			any_q     <= 1'b0;
			worst_w_q <= NONE_IDX;
			wprio_q   <= '0;
		end else if (scan_en) begin
			idx_q     <= idx_q + SRC_W'(1);
			any_q     <= any_nxt;
			worst_w_q <= worst_nxt;
			wprio_q   <= wprio_nxt;
			if (scan_last) begin
				offline_summary_q <= any_nxt;
				worst_index_q     <= worst_nxt;
			end
		end
	end

	// tick counter, timestamps and per-source flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q         <= '0;
			lost_flags_q  <= '1;
			error_flags_q <= '1;
			bad_flags_q   <= '1;
			for (int i = 0; i < NSRC; i++) begin
				seen_time_q[i]   <= '0;
				rejoin_time_q[i] <= '0;
			end
		end else if (in_acc) begin
			if (in_data.op == OP_TICK) begin
				now_q <= now_q + TIME_BITS'(1);
			end else if (32'(in_data.source) < NSRC) begin
				// source heard
				seen_time_q[in_data.source] <= now_q;
				if (lost_flags_q[in_data.source]) begin
					lost_flags_q[in_data.source]  <= 1'b0;
					rejoin_time_q[in_data.source] <= now_q;
				end
				bad_flags_q[in_data.source] <= in_data.data_bad;
				if (in_data.data_bad) begin
					error_flags_q[in_data.source] <= 1'b1;
				end
			end
		end else if (scan_en && src_en) begin
			priority if (is_off) begin
				if (!error_flags_q[idx_q]) begin
					lost_flags_q[idx_q]  <= 1'b1;
					error_flags_q[idx_q] <= 1'b1;
				end
			end else if (is_stab) begin
				lost_flags_q[idx_q]  <= 1'b0;
				error_flags_q[idx_q] <= 1'b1;
			end else begin
				lost_flags_q[idx_q]  <= 1'b0;
				error_flags_q[idx_q] <= bad_flags_q[idx_q];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q.error_bits   <= 8'(error_flags_q);
			out_data_q.lost_bits    <= 8'(lost_flags_q);
			out_data_q.any_offline  <= offline_summary_q;
			out_data_q.worst_source <= worst_index_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// checks
	`CHK_NEXT(a_tick_starts_scan, clk, arst_n, in_acc && in_data.op == OP_TICK, state_q == ST_SCAN && idx_q == '0)
	`CHK_NEXT(a_scan_ends, clk, arst_n, scan_en && scan_last, state_q == ST_DONE)
	`CHK_SAME(a_worst_none, clk, arst_n, !offline_summary_q, worst_index_q == NONE_IDX)
	`CHK_SAME(a_worst_range, clk, arst_n, offline_summary_q, worst_index_q < IDX_W'(NSRC) || worst_index_q == NONE_IDX)
	`CHK_NEXT(a_hook_clears_lost, clk, arst_n, in_acc && in_data.op == OP_HOOK, !lost_flags_q[$past(in_data.source)])

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the multi-source offline monitor
// ----------------------------------------------------------------------------
// Sends tick and heard-source requests over the valid/ready input and
// predicts the flags and scan outcome of every request with a behavioral
// model of the watchdog. Each accepted result is checked against the oldest
// prediction. A short directed table comes first. Random phases follow, each
// under its own register setting (reset values, tight limits, zero and
// all-ones extremes, wide limits, everything disabled), with random idling
// on both channels in all phases but every third one.
// ----------------------------------------------------------------------------

module tb_top;
	import msom_pkg::*;

	// settings applied between random phases
	typedef enum int {
		SET_DEFAULT,
		SET_SMALL,
		SET_MIN,
		SET_MAX,
		SET_WIDE,
		SET_QUIET
	} setting_t;

	typedef struct packed {
		in_item_t  item;
		logic      typed;
		out_item_t want;
	} dir_row_t;

	localparam int NUM_DIR    = 25;
	localparam int NUM_PHASES = 7;
	localparam int SETTLE_CYC = 12;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	in_item_t             in_data   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_item_t            out_data;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;

	// model state of the watchdog
	logic [TIME_BITS-1:0] now_t;
	logic [TIME_BITS-1:0] heard_at [NSRC];
	logic [TIME_BITS-1:0] back_at [NSRC];
	logic [NSRC-1:0]      lost_q, err_q, bad_q;
	logic                 offline_q;
	logic [IDX_W-1:0]     worst_q;

	// model copy of the registers
	logic [63:0]          off_lo, off_hi, on_lo, on_hi;
	logic [31:0]          prio_reg;
	logic [NSRC-1:0]      en_reg;

	// predicted results not yet seen
	out_item_t            flags_due [$];

	// current request as seen by the acceptance monitor
	logic                 cur_typed = 1'b0;
	out_item_t            cur_want  = '0;

	int                   send_idle_pct = 0;
	int                   recv_idle_pct = 0;
	int                   fail_count    = 0;
	int                   n_sent        = 0;
	int                   n_checked     = 0;
	int                   n_ticks       = 0;
	int                   n_heard       = 0;
	int                   n_offline     = 0;
	int                   n_settings    = 0;

	setting_t             phase_set [NUM_PHASES] = '{SET_SMALL, SET_MIN, SET_DEFAULT,
		SET_MAX, SET_WIDE, SET_QUIET, SET_SMALL};
	int                   phase_len [NUM_PHASES] = '{250, 120, 150, 120, 150, 60, 350};

	// directed table: typed rows are read straight off the reset state
	dir_row_t dir_rows [NUM_DIR] = '{
		'{'{OP_HOOK, 3'd0, 1'b0}, 1'b1, '{8'hFF, 8'hFE, 1'b0, NONE_IDX}},
		'{'{OP_TICK, 3'd0, 1'b0}, 1'b1, '{8'hFF, 8'h00, 1'b0, NONE_IDX}},
		'{'{OP_HOOK, 3'd7, 1'b1}, 1'b1, '{8'hFF, 8'h00, 1'b0, NONE_IDX}},
		'{'{OP_HOOK, 3'd3, 1'b0}, 1'b0, '0},
		'{'{OP_HOOK, 3'd5, 1'b1}, 1'b0, '0},
		'{'{OP_HOOK, 3'd0, 1'b0}, 1'b0, '0},
		'{'{OP_TICK, 3'd7, 1'b1}, 1'b0, '0},
		'{'{OP_TICK, 3'd0, 1'b0}, 1'b0, '0},
		'{'{OP_TICK, 3'd0, 1'b0}, 1'b0, '0},
		'{'{OP_TICK, 3'd0, 1'b0}, 1'b0, '0},
		'{'{OP_TICK, 3'd0, 1'b0}, 1'b0, '0},
		'{'{OP_TICK, 3'd0, 1'b0}, 1'b0, '0},
		'{'{OP_TICK, 3'd0, 1'b0}, 1'b0, '0},
		'{'{OP_TICK, 3'd0, 1'b0}, 1'b0, '0},
		'{'{OP_HOOK, 3'd2, 1'b0}, 1'b0, '0},
		'{'{OP_HOOK, 3'd4, 1'b1}, 1'b0, '0},
		'{'{OP_TICK, 3'd0, 1'b0}, 1'b0, '0},
		'{'{OP_HOOK, 3'd6, 1'b0}, 1'b0, '0},
		'{'{OP_TICK, 3'd0, 1'b0}, 1'b0, '0},
		'{'{OP_HOOK, 3'd1, 1'b1}, 1'b0, '0},
		'{'{OP_TICK, 3'd0, 1'b0}, 1'b0, '0},
		'{'{OP_HOOK, 3'd3, 1'b1}, 1'b0, '0},
		'{'{OP_TICK, 3'd0, 1'b0}, 1'b0, '0},
		'{'{OP_TICK, 3'd0, 1'b0}, 1'b0, '0},
		'{'{OP_HOOK, 3'd2, 1'b1}, 1'b0, '0}
	};

	multi_source_offline_monitor_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	// advance the watchdog model by one request and return its flags
	function automatic out_item_t watchdog_step(input in_item_t it);
		out_item_t            r;
		logic [TIME_BITS-1:0] age, settle;
		logic [LIM_W-1:0]     off_lim, on_lim;
		logic [PRIO_W-1:0]    p, best_p;
		logic [IDX_W-1:0]     best;
		logic                 hit;
		int                   i;
		if (it.op == OP_TICK) begin
			now_t  = now_t + 1'b1;
			best   = NONE_IDX;
			best_p = '0;
			hit    = 1'b0;
			for (i = 0; i < NSRC; i++) begin
				if (en_reg[i]) begin
					age     = now_t - heard_at[i];
					settle  = now_t - back_at[i];
					off_lim = (i < 4) ? off_lo[16*i +: 16] : off_hi[16*(i-4) +: 16];
					on_lim  = (i < 4) ? on_lo[16*i +: 16] : on_hi[16*(i-4) +: 16];
					p       = prio_reg[4*i +: 4];
					if (age > off_lim) begin
						// offline: only a clean source becomes lost
						if (!err_q[i]) begin
							lost_q[i] = 1'b1;
							err_q[i]  = 1'b1;
						end
						if (p > best_p) begin
							best   = IDX_W'(i);
							best_p = p;
						end
						hit = 1'b1;
					end else if (settle < on_lim) begin
						lost_q[i] = 1'b0;
						err_q[i]  = 1'b1;
					end else begin
						lost_q[i] = 1'b0;
						err_q[i]  = bad_q[i];
					end
				end
			end
			offline_q = hit;
			worst_q   = best;
			if (hit)
				n_offline++;
		end else begin
			// source heard: rejoin time moves only when it was lost
			heard_at[it.source] = now_t;
			if (lost_q[it.source]) begin
				lost_q[it.source]  = 1'b0;
				back_at[it.source] = now_t;
			end
			bad_q[it.source] = it.data_bad;
			if (it.data_bad)
				err_q[it.source] = 1'b1;
		end
		r.error_bits   = err_q;
		r.lost_bits    = lost_q;
		r.any_offline  = offline_q;
		r.worst_source = worst_q;
		return r;
	endfunction

	// four limit fields, mostly up to top, some over the full range
	function automatic logic [63:0] rand_limits(input int top, input int wide_pct);
		logic [63:0] v;
		int          k;
		for (k = 0; k < 4; k++) begin
			if ($urandom_range(0, 99) < wide_pct)
				v[16*k +: 16] = 16'($urandom_range(0, 65535));
			else
				v[16*k +: 16] = 16'($urandom_range(0, top));
		end
		return v;
	endfunction

	// receiver stalls
	always @(negedge clk)
		out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

	// prediction on acceptance, check on delivery
	always @(posedge clk) begin
		out_item_t pred, want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				pred = watchdog_step(in_data);
				flags_due.push_back(cur_typed ? cur_want : pred);
			end
			if (out_valid && out_ready) begin
				if (flags_due.size() == 0) begin
					$display("%0t: result with nothing expected: err=%h lost=%h off=%b worst=%0d",
						$time, out_data.error_bits, out_data.lost_bits,
						out_data.any_offline, out_data.worst_source);
					fail_count++;
				end else begin
					want = flags_due.pop_front();
					n_checked++;
					if (out_data !== want) begin
						$display("%0t: mismatch expected err=%h lost=%h off=%b worst=%0d",
							$time, want.error_bits, want.lost_bits,
							want.any_offline, want.worst_source);
						$display("%0t:          actual   err=%h lost=%h off=%b worst=%0d",
							$time, out_data.error_bits, out_data.lost_bits,
							out_data.any_offline, out_data.worst_source);
						fail_count++;
					end
				end
			end
		end
	end

	task automatic set_idle(input int mode);
		case (mode)
			0: begin
				send_idle_pct = 32;
				recv_idle_pct = 52;
			end
			1: begin
				send_idle_pct = 52;
				recv_idle_pct = 32;
			end
			default: begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
		endcase
	endtask

	// offer one request and hold it until accepted
	task automatic offer_request(input in_item_t it, input logic typed, input out_item_t want);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		in_data   <= it;
		cur_typed <= typed;
		cur_want  <= want;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
		n_sent++;
		if (it.op == OP_TICK)
			n_ticks++;
		else
			n_heard++;
	endtask

	// wait for all results, then let the block settle
	task automatic drain();
		while (flags_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			CFG_OFFLINE_LO: off_lo = val;
			CFG_OFFLINE_HI: off_hi = val;
			CFG_ONLINE_LO:  on_lo = val;
			CFG_ONLINE_HI:  on_hi = val;
			CFG_PRIORITIES: prio_reg = val[31:0];
			CFG_ENABLE:     en_reg = val[NSRC-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic apply_setting(input setting_t s);
		logic [63:0] v [6];
		case (s)
			SET_DEFAULT: v = '{RST_OFFLINE_LO, RST_OFFLINE_HI, RST_ONLINE_LO,
				RST_ONLINE_HI, 64'(RST_PRIORITIES), 64'(RST_ENABLE)};
			SET_MIN: v = '{64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'hFF};
			SET_MAX: v = '{'1, '1, '1, '1, 64'hFFFF_FFFF, 64'hFF};
			SET_WIDE: v = '{rand_limits(40, 40), rand_limits(40, 40), rand_limits(10, 40),
				rand_limits(10, 40), 64'($urandom), 64'($urandom_range(0, 255))};
			SET_QUIET: v = '{rand_limits(8, 0), rand_limits(8, 0), rand_limits(4, 0),
				rand_limits(4, 0), 64'($urandom), 64'd0};
			default: v = '{rand_limits(12, 0), rand_limits(12, 0), rand_limits(6, 0),
				rand_limits(6, 0), 64'($urandom), 64'($urandom_range(0, 255))};
		endcase
		write_reg(CFG_OFFLINE_LO, v[0]);
		write_reg(CFG_OFFLINE_HI, v[1]);
		write_reg(CFG_ONLINE_LO, v[2]);
		write_reg(CFG_ONLINE_HI, v[3]);
		write_reg(CFG_PRIORITIES, v[4]);
		write_reg(CFG_ENABLE, v[5]);
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	// main sequence
	initial begin
		in_item_t it;
		int       ph, n, k;
		now_t     = '0;
		lost_q    = '1;
		err_q     = '1;
		bad_q     = '1;
		offline_q = 1'b0;
		worst_q   = NONE_IDX;
		off_lo    = RST_OFFLINE_LO;
		off_hi    = RST_OFFLINE_HI;
		on_lo     = RST_ONLINE_LO;
		on_hi     = RST_ONLINE_HI;
		prio_reg  = RST_PRIORITIES;
		en_reg    = RST_ENABLE;
		for (k = 0; k < NSRC; k++) begin
			heard_at[k] = '0;
			back_at[k]  = '0;
		end

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table under reset register values
		set_idle(0);
		for (k = 0; k < NUM_DIR; k++)
			offer_request(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);
		in_valid <= 1'b0;
		drain();

		// random phases, one register setting each
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			apply_setting(phase_set[ph]);
			set_idle(ph % 3);
			for (n = 0; n < phase_len[ph]; n++) begin
				it.op       = ($urandom_range(0, 99) < 55) ? OP_TICK : OP_HOOK;
				// low sources are heard more often so some stay online
				it.source   = $urandom_range(0, 1) ? 3'($urandom_range(0, 3))
					: 3'($urandom_range(0, 7));
				it.data_bad = ($urandom_range(0, 99) < 25);
				offer_request(it, 1'b0, '0);
			end
			in_valid <= 1'b0;
			drain();
		end

		repeat (20) @(negedge clk);
		$display("covered %0d requests (%0d ticks, %0d heard) under %0d register settings",
			n_sent, n_ticks, n_heard, n_settings);
		$display("checked %0d results, %0d scans found a source offline", n_checked, n_offline);
		if (fail_count == 0 && flags_due.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// run limit
	initial begin
		#2000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
